// File: rtl/core/idea_pkg.sv
// ----------------------------------------------------------------------------
// idea_pkg
// Shared types, constants and arithmetic helpers for the IDEA encrypt pipeline.
// ----------------------------------------------------------------------------
package idea_pkg;

   localparam int WORD_W         = 16;
   localparam int KEY_W          = 128;
   localparam int HALF_KEY_W     = 64;
   localparam int BLOCK_W        = 64;
   localparam int KEY_WORDS      = 8;
   localparam int ROT_BITS       = 25;
   localparam int ROUND_KEYS     = 6;
   localparam int OUT_KEYS       = 4;
   localparam int ROUND_COUNT_DEF = 8;
   localparam int CSR_INDEX_W    = 1;

   typedef logic [WORD_W-1:0]      word_type;
   typedef word_type [0:3]         block_type;   // word 0 sits in the top bits
   typedef logic [KEY_W-1:0]       key_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // register indexes of the csr channel
   localparam csr_index_type CSR_KEY_UPPER = 1'b0;
   localparam csr_index_type CSR_KEY_LOWER = 1'b1;

   // per-round stage load enables
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } round_en_type;

   // product modulo 65537, a zero operand or result standing for 65536
   function automatic word_type mul_mod(word_type a, word_type b);
      logic [2*WORD_W-1:0] p;
      word_type            lo;
      word_type            hi;
      word_type            r;
      p  = (2*WORD_W)'(a) * (2*WORD_W)'(b);
      lo = p[WORD_W-1:0];
      hi = p[2*WORD_W-1:WORD_W];
      if (a == '0) begin
         r = word_type'(1) - b;
      end else if (b == '0) begin
         r = word_type'(1) - a;
      end else begin
         r = lo - hi + ((lo < hi) ? word_type'(1) : word_type'(0));
      end
      return r;
   endfunction

   // subkey n: word n mod 8 of the key rotated left by 25 bits per group of 8
   function automatic word_type subkey(key_type key, int n);
      int       start;
      word_type v;
      start = (ROT_BITS * (n / KEY_WORDS) + WORD_W * (n % KEY_WORDS)) % KEY_W;
      for (int i = 0; i < WORD_W; i++) begin
         v[WORD_W-1-i] = key[KEY_W-1-((start + i) % KEY_W)];
      end
      return v;
   endfunction

endpackage

// File: rtl/core/idea_block_encrypt.sv
// ----------------------------------------------------------------------------
// idea_block_encrypt
// IDEA encryption of 64-bit blocks under a 128-bit key, fully pipelined.
// ----------------------------------------------------------------------------
// Encrypts one 64-bit block per clock while rsp_tready does not stall the
// pipeline. Each round spends three stages, one per level of mod-65537
// multiplier, and the output transform one more. Every stage holds its word
// while the next stage is full, so bubbles close up and new blocks are still
// taken while a result waits on rsp_tready. The key is written as two 64-bit
// halves over the csr channel (index 0 is key bits 127..64, index 1 bits
// 63..0); the subkeys are wired straight from the key registers, so the key
// may only change while no block is in flight.
// ----------------------------------------------------------------------------
module idea_block_encrypt #(
   parameter int ROUND_COUNT = idea_pkg::ROUND_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [63:0]             req_tdata,   // [63:0] plain_block
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata,   // [63:0] cipher_block
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  idea_pkg::csr_index_type csr_index,
   input  logic [63:0]             csr_data
);
   import idea_pkg::*;

   localparam int SK_COUNT = ROUND_KEYS * ROUND_COUNT + OUT_KEYS;
   localparam int NS       = 3 * ROUND_COUNT + 1;
   localparam int OK       = ROUND_KEYS * ROUND_COUNT;

   word_type  subkeys [SK_COUNT];
   block_type round_x [ROUND_COUNT+1];
   logic [NS-1:0] valid_ff, valid_in, valid_up, stage_ready;
   block_type cipher_ff;

   idea_keysched #(
      .ROUND_COUNT(ROUND_COUNT)
   ) u_keysched (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .subkeys   (subkeys)
   );

   // a stage takes a word when it is empty or its successor moves on
   for (genvar s = 0; s < NS; s++) begin : g_ctl
      if (s == NS - 1) begin : g_last
         assign stage_ready[s] = !valid_ff[s] || rsp_tready;
      end else begin : g_mid
         assign stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   assign valid_up = {valid_ff[NS-2:0], req_tvalid};
   assign valid_in = (stage_ready & valid_up) | (~stage_ready & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_ready[0];
   assign round_x[0] = block_type'(req_tdata);

   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      word_type     rkey [ROUND_KEYS];
      round_en_type en;

      for (genvar j = 0; j < ROUND_KEYS; j++) begin : g_key
         assign rkey[j] = subkeys[ROUND_KEYS*r + j];
      end

      assign en.s1 = stage_ready[3*r];
      assign en.s2 = stage_ready[3*r+1];
      assign en.s3 = stage_ready[3*r+2];

      idea_round #(
         .LAST_ROUND(r == ROUND_COUNT - 1)
      ) u_round (
         .clock (clock),
         .en    (en),
         .x_in  (round_x[r]),
         .rkey  (rkey),
         .y_out (round_x[r+1])
      );
   end

   // output transform
   always_ff @(posedge clock) begin
      if (stage_ready[NS-1]) begin
         cipher_ff[0] <= mul_mod(round_x[ROUND_COUNT][0], subkeys[OK]);
         cipher_ff[1] <= round_x[ROUND_COUNT][1] + subkeys[OK+1];
         cipher_ff[2] <= round_x[ROUND_COUNT][2] + subkeys[OK+2];
         cipher_ff[3] <= mul_mod(round_x[ROUND_COUNT][3], subkeys[OK+3]);
      end
   end

   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = cipher_ff;

endmodule

// File: rtl/core/idea_keysched.sv
// ----------------------------------------------------------------------------
// idea_keysched
// Key registers behind the csr write channel and the fixed subkey wiring.
// ----------------------------------------------------------------------------
module idea_keysched #(
   parameter int ROUND_COUNT = idea_pkg::ROUND_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  idea_pkg::csr_index_type   csr_index,
   input  logic [63:0]               csr_data,
   output idea_pkg::word_type        subkeys [idea_pkg::ROUND_KEYS*ROUND_COUNT+idea_pkg::OUT_KEYS]
);
   import idea_pkg::*;

   localparam int SK_COUNT = ROUND_KEYS * ROUND_COUNT + OUT_KEYS;

   logic [HALF_KEY_W-1:0] key_upper_ff, key_upper_in;
   logic [HALF_KEY_W-1:0] key_lower_ff, key_lower_in;
   key_type               key;

   assign csr_ready = 1'b1;

   always_comb begin
      key_upper_in = key_upper_ff;
      key_lower_in = key_lower_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_UPPER: key_upper_in = csr_data;
            CSR_KEY_LOWER: key_lower_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else begin
         key_upper_ff <= key_upper_in;
         key_lower_ff <= key_lower_in;
      end
   end

   assign key = {key_upper_ff, key_lower_ff};

   // rotations are pure wiring
   for (genvar n = 0; n < SK_COUNT; n++) begin : g_sk
      assign subkeys[n] = subkey(key, n);
   end

endmodule

// File: rtl/core/idea_round.sv
// ----------------------------------------------------------------------------
// idea_round
// One IDEA round in three register stages, one multiplier level per stage.
// ----------------------------------------------------------------------------
module idea_round #(
   parameter bit LAST_ROUND = 1'b0
) (
   input  logic                   clock,
   input  idea_pkg::round_en_type en,
   input  idea_pkg::block_type    x_in,
   input  idea_pkg::word_type     rkey [idea_pkg::ROUND_KEYS],
   output idea_pkg::block_type    y_out
);
   import idea_pkg::*;

   word_type a1_ff, b1_ff, c1_ff, d1_ff;
   word_type a2_ff, b2_ff, c2_ff, d2_ff, t1_2_ff;
   word_type a3_ff, b3_ff, c3_ff, d3_ff, t1_3_ff, t2_3_ff;
   word_type t2_in;
   word_type t3;

   // stage 1: key mixing of the four words
   always_ff @(posedge clock) begin
      if (en.s1) begin
         a1_ff <= mul_mod(x_in[0], rkey[0]);
         b1_ff <= x_in[1] + rkey[1];
         c1_ff <= x_in[2] + rkey[2];
         d1_ff <= mul_mod(x_in[3], rkey[3]);
      end
   end

   // stage 2: first multiply of the ma structure
   always_ff @(posedge clock) begin
      if (en.s2) begin
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         c2_ff   <= c1_ff;
         d2_ff   <= d1_ff;
         t1_2_ff <= mul_mod(a1_ff ^ c1_ff, rkey[4]);
      end
   end

   // stage 3: second multiply of the ma structure
   assign t2_in = mul_mod((b2_ff ^ d2_ff) + t1_2_ff, rkey[5]);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         a3_ff   <= a2_ff;
         b3_ff   <= b2_ff;
         c3_ff   <= c2_ff;
         d3_ff   <= d2_ff;
         t1_3_ff <= t1_2_ff;
         t2_3_ff <= t2_in;
      end
   end

   assign t3 = t1_3_ff + t2_3_ff;

   always_comb begin
      y_out[0] = a3_ff ^ t2_3_ff;
      y_out[3] = d3_ff ^ t3;
      if (LAST_ROUND) begin
         y_out[1] = b3_ff ^ t3;
         y_out[2] = c3_ff ^ t2_3_ff;
      end else begin
         y_out[1] = c3_ff ^ t2_3_ff;
         y_out[2] = b3_ff ^ t3;
      end
   end

endmodule
